// ----- rtl/core/utf8_to_utf16_transcoder_defines.svh -----
// Assertion macros shared by the transcoder RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/u8u16_pkg.sv -----
// Types, constants and the code point to UTF-16 helper for the transcoder.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE        = 21'h10000;
    localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
    localparam logic [7:0]  CONT_MASK        = 8'hC0;
    localparam logic [7:0]  CONT_TAG         = 8'h80;
    localparam logic [7:0]  LEAD2_MASK       = 8'hE0;
    localparam logic [7:0]  LEAD2_TAG        = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK       = 8'hF0;
    localparam logic [7:0]  LEAD3_TAG        = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK       = 8'hF8;
    localparam logic [7:0]  LEAD4_TAG        = 8'hF0;
    localparam logic [7:0]  PAYLOAD_MASK     = 8'h3F;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        run_last;
        logic        text_done;
    } result_t;

    // Up to two results caused by one byte; first is emitted first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } pair_t;

    typedef struct packed {
        logic        is_pair;
        logic [15:0] hi;    // single unit when not a pair
        logic [15:0] lo;
    } units_t;

    function automatic units_t cp_units(input logic [20:0] cp);
        logic [20:0] cp_eff;
        logic [20:0] v;
        units_t      u;
        cp_eff = (cp > MAX_CODE_POINT) ? {5'd0, REPLACEMENT_UNIT} : cp;
        v      = cp_eff - SUPP_BASE;
        u.is_pair = (cp_eff >= SUPP_BASE);
        if (u.is_pair)
        begin
            u.hi = HIGH_SURR_BASE + {6'd0, v[19:10]};
            u.lo = LOW_SURR_BASE + {6'd0, v[9:0]};
        end
        else
        begin
            u.hi = cp_eff[15:0];
            u.lo = 16'd0;
        end
        return u;
    endfunction

endpackage

// ----- rtl/core/u8u16_decode.sv -----
// Combinational UTF-8 step: byte plus decoder state in, results and next state out.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic [7:0]  text_byte,
    input  logic [20:0] partial,
    input  logic [1:0]  remaining,
    output pair_t       pair,
    output logic [20:0] partial_next,
    output logic [1:0]  remaining_next
);

    logic        is_cont;
    logic [20:0] cp_cont;
    units_t      units;
    logic        lead_emit;
    result_t     lead_res;
    logic [20:0] lead_partial;
    logic [1:0]  lead_rem;

    assign is_cont = ((text_byte & CONT_MASK) == CONT_TAG);
    assign cp_cont = {partial[14:0], text_byte[5:0] & PAYLOAD_MASK[5:0]};
    assign units   = cp_units(cp_cont);

    // Byte taken as the start of a sequence.
    always_comb
    begin
        lead_emit    = 1'b1;
        lead_partial = 21'd0;
        lead_rem     = 2'd0;
        lead_res     = '{code_unit: REPLACEMENT_UNIT, unit_valid: 1'b1,
                         run_last: 1'b1, text_done: 1'b0};
        if (text_byte == 8'd0)
        begin
            lead_res = '{code_unit: 16'd0, unit_valid: 1'b0,
                         run_last: 1'b1, text_done: 1'b1};
        end
        else if (!text_byte[7])
        begin
            lead_res.code_unit = {8'd0, text_byte};
        end
        else if ((text_byte & LEAD2_MASK) == LEAD2_TAG)
        begin
            lead_emit    = 1'b0;
            lead_partial = {16'd0, text_byte[4:0]};
            lead_rem     = 2'd1;
        end
        else if ((text_byte & LEAD3_MASK) == LEAD3_TAG)
        begin
            lead_emit    = 1'b0;
            lead_partial = {17'd0, text_byte[3:0]};
            lead_rem     = 2'd2;
        end
        else if ((text_byte & LEAD4_MASK) == LEAD4_TAG)
        begin
            lead_emit    = 1'b0;
            lead_partial = {18'd0, text_byte[2:0]};
            lead_rem     = 2'd3;
        end
    end

    always_comb
    begin
        pair           = '0;
        partial_next   = lead_partial;
        remaining_next = lead_rem;
        if (remaining != 2'd0 && is_cont)
        begin
            if (remaining == 2'd1)
            begin
                partial_next   = 21'd0;
                remaining_next = 2'd0;
                pair.first     = '{code_unit: units.hi, unit_valid: 1'b1,
                                   run_last: !units.is_pair, text_done: 1'b0};
                pair.second    = '{code_unit: units.lo, unit_valid: 1'b1,
                                   run_last: 1'b1, text_done: 1'b0};
                pair.count     = units.is_pair ? 2'd2 : 2'd1;
            end
            else
            begin
                partial_next   = cp_cont;
                remaining_next = remaining - 2'd1;
            end
        end
        else if (remaining != 2'd0)
        begin
            // missing continuation: U+FFFD, then the byte again as a lead
            pair.first  = '{code_unit: REPLACEMENT_UNIT, unit_valid: 1'b1,
                            run_last: !lead_emit, text_done: 1'b0};
            pair.second = lead_res;
            pair.count  = lead_emit ? 2'd2 : 2'd1;
        end
        else
        begin
            pair.first = lead_res;
            pair.count = {1'b0, lead_emit};
        end
    end

endmodule

// ----- rtl/core/u8u16_out_buf.sv -----
// Two-slot result register; drains one result per output beat.
// Depends on u8u16_pkg and utf8_to_utf16_transcoder_defines.svh.
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_out_buf
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  pair_t       pair,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        unit_valid,
    output logic        run_last,
    output logic        text_done
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (load)
        begin
            cnt_next  = pair.count;
            head_next = pair.first;
            tail_next = pair.second;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign code_unit  = head_reg.code_unit;
    assign unit_valid = head_reg.unit_valid;
    assign run_last   = head_reg.run_last;
    assign text_done  = head_reg.text_done;

    `U8U16_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `U8U16_ASSERT_NOW(a_head_not_last, clk, rst_n, cnt_reg == 2'd2, !head_reg.run_last)
    `U8U16_ASSERT_NOW(a_single_is_last, clk, rst_n, cnt_reg == 2'd1, head_reg.run_last)
    `U8U16_ASSERT_NOW(a_done_shape, clk, rst_n, out_valid && head_reg.text_done,
                      head_reg.run_last && !head_reg.unit_valid)
    `U8U16_ASSERT_NEXT(a_pair_drains, clk, rst_n, pop && cnt_reg == 2'd2 && !load,
                       cnt_reg == 2'd1)

endmodule

// ----- rtl/core/utf8_to_utf16_transcoder.sv -----
// UTF-8 to UTF-16 transcoder, top level.
// An accepted byte is held in the input register, then its results load into the result buffer.
// Throughput: one byte per cycle; out_ready stalls and bytes that yield two units hold the input.
// Bytes that yield no unit (lead and middle continuation bytes) emit nothing.
// Reset (rst_n low, async): input stage and result buffer empty, decoder state idle.
// Depends on u8u16_pkg, u8u16_decode and u8u16_out_buf.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        unit_valid,
    output logic        run_last,
    output logic        text_done
);

    // Input register stage: holds one byte ahead of the decoder.
    logic        in_v_reg, in_v_next;
    logic [7:0]  byte_reg, byte_next;

    // Decoder state: code point bits so far and continuation bytes still due.
    logic [20:0] partial_reg, partial_next;
    logic [1:0]  rem_reg, rem_next;
    logic [20:0] dec_partial;
    logic [1:0]  dec_rem;

    pair_t       dec_pair;
    logic        can_load;
    logic        advance;

    // The held byte moves into the result buffer once that buffer is free
    // (or is giving up its last result in this same cycle).
    assign advance  = in_v_reg && can_load;
    assign in_ready = !in_v_reg || can_load;

    always_comb
    begin
        in_v_next = in_v_reg;
        byte_next = byte_reg;
        if (in_valid && in_ready)
        begin
            in_v_next = 1'b1;
            byte_next = text_byte;
        end
        else if (advance)
        begin
            in_v_next = 1'b0;
        end
    end

    // State only moves when a byte is actually consumed by the decoder.
    assign partial_next = advance ? dec_partial : partial_reg;
    assign rem_next     = advance ? dec_rem : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg    <= 1'b0;
            partial_reg <= 21'd0;
            rem_reg     <= 2'd0;
        end
        else
        begin
            in_v_reg    <= in_v_next;
            partial_reg <= partial_next;
            rem_reg     <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    u8u16_decode u_decode (
        .text_byte      (byte_reg),
        .partial        (partial_reg),
        .remaining      (rem_reg),
        .pair           (dec_pair),
        .partial_next   (dec_partial),
        .remaining_next (dec_rem)
    );

    // Result buffer: a byte yielding zero results loads an empty pair.
    u8u16_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .pair       (dec_pair),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .unit_valid (unit_valid),
        .run_last   (run_last),
        .text_done  (text_done)
    );

endmodule

// ----- bench/tb_utf8_to_utf16_transcoder.sv -----
// Self-checking bench for utf8_to_utf16_transcoder: byte beats in, UTF-16 unit beats out.
// A scoreboard class predicts the units of every accepted byte; depends on u8u16_pkg.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder;
    import u8u16_pkg::*;

    localparam int NUM_RANDOM_BYTES = 1000;
    localparam int QUIET_TAIL       = 150;   // bytes at the end sent with no idling
    localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES     = 8;     // margin after the last owed unit

    // Scoreboard: a copy of the decoder state, plus the units still owed by the block.
    class utf16_unit_board;
        logic [20:0] partial_cp;
        logic [1:0]  conts_left;
        result_t     awaited_units[$];
        result_t     step_units[$];   // units produced by the byte being decoded
        int          errors;

        function new();
            partial_cp = '0;
            conts_left = '0;
            errors     = 0;
        endfunction

        function void report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endfunction

        function void emit(logic [15:0] unit, logic valid, logic done);
            result_t r;
            r.code_unit  = unit;
            r.unit_valid = valid;
            r.run_last   = 1'b0;
            r.text_done  = done;
            step_units   = {step_units, r};
        endfunction

        // Clamp to the replacement char past the Unicode range, split supplementary
        // planes into a high/low surrogate pair.
        function void emit_code_point(logic [20:0] cp);
            logic [20:0] eff;
            logic [20:0] ofs;
            eff = (cp > MAX_CODE_POINT) ? {5'd0, REPLACEMENT_UNIT} : cp;
            if (eff >= SUPP_BASE)
            begin
                ofs = eff - SUPP_BASE;
                emit(HIGH_SURR_BASE + {6'd0, ofs[19:10]}, 1'b1, 1'b0);
                emit(LOW_SURR_BASE + {6'd0, ofs[9:0]}, 1'b1, 1'b0);
            end
            else
            begin
                emit(eff[15:0], 1'b1, 1'b0);
            end
        endfunction

        // Byte seen with nothing pending: terminator, ASCII, a lead, or junk.
        function void start_sequence(logic [7:0] b);
            partial_cp = '0;
            conts_left = '0;
            if (b == 8'h00)
            begin
                emit(16'h0000, 1'b0, 1'b1);
            end
            else if (b < CONT_TAG)
            begin
                emit_code_point({13'd0, b});
            end
            else if ((b & LEAD2_MASK) == LEAD2_TAG)
            begin
                partial_cp = {16'd0, b[4:0]};
                conts_left = 2'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3_TAG)
            begin
                partial_cp = {17'd0, b[3:0]};
                conts_left = 2'd2;
            end
            else if ((b & LEAD4_MASK) == LEAD4_TAG)
            begin
                partial_cp = {18'd0, b[2:0]};
                conts_left = 2'd3;
            end
            else
            begin
                // stray continuation or a 0xF8+ byte
                emit_code_point({5'd0, REPLACEMENT_UNIT});
            end
        endfunction

        function void note_byte(logic [7:0] b);
            logic [20:0] done_cp;
            step_units.delete();
            if (conts_left != 2'd0)
            begin
                if ((b & CONT_MASK) == CONT_TAG)
                begin
                    partial_cp = {partial_cp[14:0], b[5:0]};
                    conts_left = conts_left - 2'd1;
                    if (conts_left == 2'd0)
                    begin
                        done_cp    = partial_cp;
                        partial_cp = '0;
                        emit_code_point(done_cp);
                    end
                end
                else
                begin
                    // sequence cut short: replacement, then the byte again as a lead
                    emit_code_point({5'd0, REPLACEMENT_UNIT});
                    start_sequence(b);
                end
            end
            else
            begin
                start_sequence(b);
            end
            if (step_units.size() > 0)
            begin
                step_units[step_units.size() - 1].run_last = 1'b1;
            end
            awaited_units = {awaited_units, step_units};
        endfunction

        function void check_unit(result_t got);
            result_t want;
            if (awaited_units.size() == 0)
            begin
                report($sformatf("unexpected beat unit=%h valid=%b last=%b done=%b",
                                 got.code_unit, got.unit_valid, got.run_last, got.text_done));
                return;
            end
            want = awaited_units.pop_front();
            if (got.code_unit !== want.code_unit)
            begin
                report($sformatf("code_unit %h, want %h", got.code_unit, want.code_unit));
            end
            if (got.unit_valid !== want.unit_valid)
            begin
                report($sformatf("unit_valid %b, want %b", got.unit_valid, want.unit_valid));
            end
            if (got.run_last !== want.run_last)
            begin
                report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
            end
            if (got.text_done !== want.text_done)
            begin
                report($sformatf("text_done %b, want %b", got.text_done, want.text_done));
            end
        endfunction

        function int owed();
            return awaited_units.size();
        endfunction

        function void check_drained();
            if (awaited_units.size() != 0)
            begin
                report($sformatf("%0d units never arrived", awaited_units.size()));
            end
        endfunction
    endclass

    // Clock, reset and block I/O; every input starts at a known value.
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte  = 8'h00;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        run_last;
    logic        text_done;

    utf16_unit_board board = new();

    int bytes_sent   = 0;
    int in_gap_pct   = 0;   // chance of a sender idle burst before a beat
    int out_gap_pct  = 0;   // chance of a receiver stall burst per cycle
    int stall_left   = 0;
    int idle_cycles  = 0;

    // Directed opener: ASCII extremes, each sequence length, a surrogate pair,
    // an out-of-range 4-byte form, stray continuation, invalid leads, a sequence
    // broken by ASCII, and one truncated by the terminator.
    logic [7:0] opener_bytes [0:22] = '{
        8'h00,
        8'h01, 8'h7F,
        8'hC2, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'h80,
        8'hF8, 8'hFF,
        8'hE2, 8'h41,
        8'hC3, 8'h00
    };

    utf8_to_utf16_transcoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .unit_valid (unit_valid),
        .run_last   (run_last),
        .text_done  (text_done)
    );

    always #5 clk = ~clk;

    // Monitor: beats are sampled at the rising edge; inputs only move on the
    // falling edge, so there is no race with the driver.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                board.note_byte(text_byte);
            end
            if (out_valid && out_ready)
            begin
                got.code_unit  = code_unit;
                got.unit_valid = unit_valid;
                got.run_last   = run_last;
                got.text_done  = text_done;
                board.check_unit(got);
            end
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_utf8_to_utf16_transcoder failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver: ready drops in bursts of random length when stalls are enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (out_gap_pct > 0 && $urandom_range(1, 100) <= out_gap_pct)
        begin
            stall_left <= $urandom_range(0, 6);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // One byte beat. An optional idle burst comes first; valid then stays high
    // with the byte held until the block takes it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Well-formed sequence of the given length with random payload bits. The
    // 4-byte leads reach past U+10FFFF, so the clamp gets exercised too.
    task automatic send_sequence(input int len);
        case (len)
            1: send_byte(8'($urandom_range(1, 127)));
            2: send_byte(8'hC0 | 8'($urandom_range(0, 31)));
            3: send_byte(8'hE0 | 8'($urandom_range(0, 15)));
            default: send_byte(8'hF0 | 8'($urandom_range(0, 7)));
        endcase
        repeat (len - 1)
        begin
            send_byte(CONT_TAG | 8'($urandom_range(0, 63)));
        end
    endtask

    // Main sequence: reset, directed opener, then mostly well-formed text with
    // terminators and noise mixed in. Idle rates change every 100 bytes.
    initial
    begin
        int pick;
        int burst;
        int rate_block;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        in_gap_pct  = 20;
        out_gap_pct = 20;
        foreach (opener_bytes[i])
        begin
            send_byte(opener_bytes[i]);
        end

        rate_block = -1;
        bytes_sent = 0;
        while (bytes_sent < NUM_RANDOM_BYTES)
        begin
            if (bytes_sent >= NUM_RANDOM_BYTES - QUIET_TAIL)
            begin
                in_gap_pct  = 0;
                out_gap_pct = 0;
            end
            else if (bytes_sent / 100 != rate_block)
            begin
                rate_block = bytes_sent / 100;
                case ($urandom_range(0, 2))
                    0: in_gap_pct = 0;
                    1: in_gap_pct = 15;
                    default: in_gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: out_gap_pct = 0;
                    1: out_gap_pct = 15;
                    default: out_gap_pct = 40;
                endcase
            end

            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_byte(8'h00);
            end
            else if (pick < 82)
            begin
                send_sequence($urandom_range(1, 4));
            end
            else
            begin
                // noise: stray continuations, bad leads, cut-off sequences
                burst = $urandom_range(1, 3);
                repeat (burst)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Wait for every owed unit, then for the drain margin to catch anything extra.
        while (board.owed() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.check_drained();

        if (board.errors == 0)
        begin
            $display("tb_utf8_to_utf16_transcoder passed");
        end
        else
        begin
            $display("tb_utf8_to_utf16_transcoder failed");
        end
        $finish;
    end

endmodule
